@@ hdl/pap_pkg.sv @@
// Package for the pattern avoidance probability block: sizes, codes, types.
// No dependencies; every other file but pap_ram refers to it by scoped names.
`timescale 1ns / 1ps

package pap_pkg;

    localparam int ALPHABET   = 64;
    localparam int SYM_W      = 6;
    localparam int MAX_NODES  = 512;
    localparam int NODE_W     = 9;
    localparam int CNT_W      = 10;
    localparam int LEN_W      = 7;
    localparam int DRAWN_W    = 7;
    localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
    localparam int GOTO_AW    = NODE_W + SYM_W;
    localparam int VAL_DEPTH  = 2 * MAX_NODES;
    localparam int VAL_AW     = NODE_W + 1;
    localparam int Q_W        = 32;
    localparam int ACC_W      = 40;
    localparam int FRAC_W     = 31;

    localparam logic [Q_W-1:0]     Q_ONE      = 32'h8000_0000;
    localparam logic [CNT_W-1:0]   MAX_CNT    = CNT_W'(MAX_NODES);
    localparam logic [DRAWN_W-1:0] ALPHA_CNT  = DRAWN_W'(ALPHABET);
    localparam logic [SYM_W-1:0]   LAST_SYM   = SYM_W'(ALPHABET - 1);

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_PROB    = 2'd2,
        OP_RUN     = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_CLR_ROW,
        S_IDLE,
        S_INS_RD,
        S_INS_END,
        S_B_SYM_RD,
        S_B_SYM_EV,
        S_B_MARK,
        S_B_NODE,
        S_B_FAIL,
        S_B_FAIL2,
        S_D_INIT,
        S_D_NODE,
        S_D_RUN,
        S_D_OUT,
        S_D_RES
    } state_t;

    typedef struct packed {
        logic vld;
        logic last;
        logic skip;
    } mac_ctl_t;

    localparam logic [0:0] REG_SYMBOLS_IN_USE = 1'b0;

endpackage

@@ hdl/pap_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Uses no package; sized by its parameters.
`timescale 1ns / 1ps

module pap_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 9,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pap_mac.sv @@
// Multiply-accumulate for one node sum: registered product, then summing
// with saturation to 1.0. Depends on pap_pkg.
`timescale 1ns / 1ps

module pap_mac (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pap_pkg::mac_ctl_t         ctl,
    input  logic [pap_pkg::Q_W-1:0]   prob,
    input  logic [pap_pkg::Q_W-1:0]   value,
    output logic                      done,
    output logic [pap_pkg::Q_W-1:0]   sum
);

    pap_pkg::mac_ctl_t               ctl_reg;
    logic [2*pap_pkg::Q_W-1:0]       prod_reg;
    logic [pap_pkg::ACC_W-1:0]       acc_reg;
    logic [pap_pkg::ACC_W-1:0]       acc_next;
    logic [pap_pkg::ACC_W-1:0]       total;
    logic [pap_pkg::ACC_W-1:0]       term;

    always_ff @(posedge clk)
    begin
        prod_reg <= prob * value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        term = ctl_reg.skip ? '0
             : pap_pkg::ACC_W'(prod_reg[2*pap_pkg::Q_W-1:pap_pkg::FRAC_W]);
        total = acc_reg + term;
        acc_next = acc_reg;
        if (ctl_reg.vld)
        begin
            acc_next = ctl_reg.last ? '0 : total;
        end
        done = ctl_reg.vld & ctl_reg.last;
        sum  = (total > pap_pkg::ACC_W'(pap_pkg::Q_ONE)) ? pap_pkg::Q_ONE
             : total[pap_pkg::Q_W-1:0];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.vld && !ctl_reg.last |=> acc_reg != '0 || $past(term) == '0)
        else $error("accumulator lost a term");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> acc_reg == '0)
        else $error("accumulator not cleared after node sum");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> sum <= pap_pkg::Q_ONE)
        else $error("node sum above one");

endmodule

@@ hdl/pap_engine.sv @@
// Sequencer for trie insertion, failure-link build and the avoidance
// recurrence; owns the table RAMs. Depends on pap_pkg, pap_ram, pap_mac.
`timescale 1ns / 1ps

module pap_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [pap_pkg::SYM_W-1:0]     symbol,
    input  logic                          last_of_pattern,
    input  logic [pap_pkg::Q_W-1:0]       probability,
    input  logic [pap_pkg::LEN_W-1:0]     run_length,
    input  logic [pap_pkg::DRAWN_W-1:0]   symbols_in_use,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pap_pkg::Q_W-1:0]       avoid_probability,
    output logic                          table_full
);

    localparam int NW = pap_pkg::NODE_W;
    localparam int SW = pap_pkg::SYM_W;

    pap_pkg::state_t              state_reg, state_next;
    logic [pap_pkg::CNT_W-1:0]    node_count_reg, node_count_next;
    logic [NW-1:0]                cursor_reg, cursor_next;
    logic                         overflow_reg, overflow_next;
    logic                         built_reg, built_next;
    logic                         dropped_reg, dropped_next;
    logic [SW-1:0]                sym_reg, sym_next;
    logic                         last_reg, last_next;
    logic [pap_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [NW-1:0]                clr_row_reg, clr_row_next;
    logic                         clr_idle_reg, clr_idle_next;
    logic [SW-1:0]                c_reg, c_next;
    logic [NW-1:0]                r_reg, r_next;
    logic [NW-1:0]                fr_reg, fr_next;
    logic                         root_reg, root_next;
    logic [pap_pkg::CNT_W-1:0]    head_reg, head_next;
    logic [pap_pkg::CNT_W-1:0]    tail_reg, tail_next;
    logic [NW-1:0]                bu_reg, bu_next;
    logic [NW-1:0]                u_reg, u_next;
    logic [pap_pkg::LEN_W-1:0]    l_reg, l_next;
    logic [pap_pkg::DRAWN_W-1:0]  i_reg, i_next;
    logic                         cur_reg, cur_next;
    logic                         s1_vld_reg, s1_vld_next;
    logic                         s1_last_reg, s1_last_next;
    pap_pkg::mac_ctl_t            s2_ctl_reg, s2_ctl_next;
    logic [pap_pkg::Q_W-1:0]      s2_prob_reg, s2_prob_next;
    logic                         out_valid_reg, out_valid_next;
    logic [pap_pkg::Q_W-1:0]      out_prob_reg, out_prob_next;
    logic                         out_full_reg, out_full_next;

    logic                         goto_we;
    logic [pap_pkg::GOTO_AW-1:0]  goto_wa;
    logic [NW-1:0]                goto_wd;
    logic                         goto_a_re, goto_b_re;
    logic [pap_pkg::GOTO_AW-1:0]  goto_a_ra, goto_b_ra;
    logic [NW-1:0]                goto_a_q, goto_b_q;
    logic                         mark_we, mark_wd;
    logic [NW-1:0]                mark_wa;
    logic                         mark_a_re, mark_b_re;
    logic [NW-1:0]                mark_a_ra, mark_b_ra;
    logic                         mark_a_q, mark_b_q;
    logic                         fail_we, fail_re;
    logic [NW-1:0]                fail_wa, fail_wd, fail_ra, fail_q;
    logic                         queue_we, queue_re;
    logic [NW-1:0]                queue_wa, queue_wd, queue_ra, queue_q;
    logic                         prob_we, prob_re;
    logic [SW-1:0]                prob_wa, prob_ra;
    logic [pap_pkg::Q_W-1:0]      prob_q;
    logic                         val_we, val_re;
    logic [pap_pkg::VAL_AW-1:0]   val_wa, val_ra;
    logic [pap_pkg::Q_W-1:0]      val_wd, val_q;

    logic                         mac_done;
    logic [pap_pkg::Q_W-1:0]      mac_sum;
    pap_pkg::mac_ctl_t            mac_ctl;
    logic [pap_pkg::DRAWN_W-1:0]  drawn;
    logic [NW-1:0]                last_node;
    logic [NW-1:0]                g_eff;
    logic                         node_end;

    pap_ram #(.DEPTH(pap_pkg::GOTO_DEPTH), .WIDTH(NW)) u_goto_a (
        .clk(clk), .we(goto_we), .waddr(goto_wa), .wdata(goto_wd),
        .re(goto_a_re), .raddr(goto_a_ra), .rdata(goto_a_q));
    pap_ram #(.DEPTH(pap_pkg::GOTO_DEPTH), .WIDTH(NW)) u_goto_b (
        .clk(clk), .we(goto_we), .waddr(goto_wa), .wdata(goto_wd),
        .re(goto_b_re), .raddr(goto_b_ra), .rdata(goto_b_q));
    pap_ram #(.DEPTH(pap_pkg::MAX_NODES), .WIDTH(1)) u_mark_a (
        .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
        .re(mark_a_re), .raddr(mark_a_ra), .rdata(mark_a_q));
    pap_ram #(.DEPTH(pap_pkg::MAX_NODES), .WIDTH(1)) u_mark_b (
        .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
        .re(mark_b_re), .raddr(mark_b_ra), .rdata(mark_b_q));
    pap_ram #(.DEPTH(pap_pkg::MAX_NODES), .WIDTH(NW)) u_fail (
        .clk(clk), .we(fail_we), .waddr(fail_wa), .wdata(fail_wd),
        .re(fail_re), .raddr(fail_ra), .rdata(fail_q));
    pap_ram #(.DEPTH(pap_pkg::MAX_NODES), .WIDTH(NW)) u_queue (
        .clk(clk), .we(queue_we), .waddr(queue_wa), .wdata(queue_wd),
        .re(queue_re), .raddr(queue_ra), .rdata(queue_q));
    pap_ram #(.DEPTH(pap_pkg::ALPHABET), .WIDTH(pap_pkg::Q_W)) u_prob (
        .clk(clk), .we(prob_we), .waddr(prob_wa), .wdata(probability),
        .re(prob_re), .raddr(prob_ra), .rdata(prob_q));
    pap_ram #(.DEPTH(pap_pkg::VAL_DEPTH), .WIDTH(pap_pkg::Q_W)) u_val (
        .clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_wd),
        .re(val_re), .raddr(val_ra), .rdata(val_q));

    pap_mac u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(mac_ctl), .prob(s2_prob_reg),
        .value(val_q), .done(mac_done), .sum(mac_sum));

    assign drawn     = (symbols_in_use > pap_pkg::ALPHA_CNT) ? pap_pkg::ALPHA_CNT
                     : symbols_in_use;
    assign last_node = NW'(node_count_reg - 1'b1);
    assign g_eff     = root_reg ? '0 : goto_b_q;
    assign in_ready  = (state_reg == pap_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign avoid_probability = out_prob_reg;
    assign table_full = out_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pap_pkg::S_CLR_ROW;
            node_count_reg <= pap_pkg::CNT_W'(1);
            cursor_reg     <= '0;
            overflow_reg   <= 1'b0;
            built_reg      <= 1'b0;
            dropped_reg    <= 1'b0;
            clr_row_reg    <= '0;
            clr_idle_reg   <= 1'b1;
            c_reg          <= '0;
            root_reg       <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            u_reg          <= '0;
            l_reg          <= '0;
            i_reg          <= '0;
            cur_reg        <= 1'b0;
            s1_vld_reg     <= 1'b0;
            s1_last_reg    <= 1'b0;
            s2_ctl_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            cursor_reg     <= cursor_next;
            overflow_reg   <= overflow_next;
            built_reg      <= built_next;
            dropped_reg    <= dropped_next;
            clr_row_reg    <= clr_row_next;
            clr_idle_reg   <= clr_idle_next;
            c_reg          <= c_next;
            root_reg       <= root_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            u_reg          <= u_next;
            l_reg          <= l_next;
            i_reg          <= i_next;
            cur_reg        <= cur_next;
            s1_vld_reg     <= s1_vld_next;
            s1_last_reg    <= s1_last_next;
            s2_ctl_reg     <= s2_ctl_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        len_reg      <= len_next;
        r_reg        <= r_next;
        fr_reg       <= fr_next;
        bu_reg       <= bu_next;
        s2_prob_reg  <= s2_prob_next;
        out_prob_reg <= out_prob_next;
        out_full_reg <= out_full_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        cursor_next     = cursor_reg;
        overflow_next   = overflow_reg;
        built_next      = built_reg;
        dropped_next    = dropped_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        len_next        = len_reg;
        clr_row_next    = clr_row_reg;
        clr_idle_next   = clr_idle_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        fr_next         = fr_reg;
        root_next       = root_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        bu_next         = bu_reg;
        u_next          = u_reg;
        l_next          = l_reg;
        i_next          = i_reg;
        cur_next        = cur_reg;
        s1_vld_next     = 1'b0;
        s1_last_next    = 1'b0;
        s2_ctl_next     = '0;
        s2_prob_next    = prob_q;
        out_valid_next  = out_valid_reg & ~out_ready;
        out_prob_next   = out_prob_reg;
        out_full_next   = out_full_reg;
        node_end        = 1'b0;

        goto_we   = 1'b0;  goto_wa = '0;  goto_wd = '0;
        goto_a_re = 1'b0;  goto_a_ra = '0;
        goto_b_re = 1'b0;  goto_b_ra = '0;
        mark_we   = 1'b0;  mark_wa = '0;  mark_wd = 1'b0;
        mark_a_re = 1'b0;  mark_a_ra = '0;
        mark_b_re = 1'b0;  mark_b_ra = '0;
        fail_we   = 1'b0;  fail_wa = '0;  fail_wd = '0;
        fail_re   = 1'b0;  fail_ra = '0;
        queue_we  = 1'b0;  queue_wa = '0; queue_wd = '0;
        queue_re  = 1'b0;  queue_ra = '0;
        prob_we   = 1'b0;  prob_wa = symbol;
        prob_re   = 1'b0;  prob_ra = '0;
        val_we    = 1'b0;  val_wa = '0;   val_wd = '0;
        val_re    = 1'b0;  val_ra = '0;

        // lookahead pipeline of the recurrence: stage 1 gets goto/prob data
        if (s1_vld_reg)
        begin
            mark_a_re = 1'b1;
            mark_a_ra = goto_a_q;
            val_re    = 1'b1;
            val_ra    = {cur_reg, goto_a_q};
        end
        s2_ctl_next.vld  = s1_vld_reg;
        s2_ctl_next.last = s1_last_reg;
        s2_ctl_next.skip = 1'b0;

        unique case (state_reg)
            pap_pkg::S_CLR_ROW:
            begin
                goto_we = 1'b1;
                goto_wa = {clr_row_reg, c_reg};
                goto_wd = '0;
                if (c_reg == '0)
                begin
                    mark_we = 1'b1;
                    mark_wa = clr_row_reg;
                    mark_wd = 1'b0;
                end
                c_next = c_reg + 1'b1;
                if (c_reg == pap_pkg::LAST_SYM)
                begin
                    state_next = clr_idle_reg ? pap_pkg::S_IDLE : pap_pkg::S_INS_END;
                end
            end

            pap_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next  = symbol;
                    last_next = last_of_pattern;
                    len_next  = run_length;
                    unique case (pap_pkg::op_t'(op))
                        pap_pkg::OP_CLEAR:
                        begin
                            node_count_next = pap_pkg::CNT_W'(1);
                            cursor_next     = '0;
                            overflow_next   = 1'b0;
                            built_next      = 1'b0;
                            dropped_next    = 1'b0;
                            clr_row_next    = '0;
                            clr_idle_next   = 1'b1;
                            c_next          = '0;
                            state_next      = pap_pkg::S_CLR_ROW;
                        end
                        pap_pkg::OP_PATTERN:
                        begin
                            if (!built_reg)
                            begin
                                if (dropped_reg)
                                begin
                                    state_next = pap_pkg::S_INS_END;
                                end
                                else
                                begin
                                    goto_a_re  = 1'b1;
                                    goto_a_ra  = {cursor_reg, symbol};
                                    state_next = pap_pkg::S_INS_RD;
                                end
                            end
                        end
                        pap_pkg::OP_PROB:
                        begin
                            prob_we = 1'b1;
                        end
                        pap_pkg::OP_RUN:
                        begin
                            if (built_reg)
                            begin
                                u_next     = '0;
                                state_next = pap_pkg::S_D_INIT;
                            end
                            else
                            begin
                                r_next     = '0;
                                fr_next    = '0;
                                root_next  = 1'b1;
                                c_next     = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                state_next = pap_pkg::S_B_SYM_RD;
                            end
                        end
                        default:
                        begin
                            state_next = pap_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            pap_pkg::S_INS_RD:
            begin
                if (goto_a_q != '0)
                begin
                    cursor_next = goto_a_q;
                    state_next  = pap_pkg::S_INS_END;
                end
                else if (node_count_reg < pap_pkg::MAX_CNT)
                begin
                    goto_we         = 1'b1;
                    goto_wa         = {cursor_reg, sym_reg};
                    goto_wd         = NW'(node_count_reg);
                    node_count_next = node_count_reg + 1'b1;
                    cursor_next     = NW'(node_count_reg);
                    clr_row_next    = NW'(node_count_reg);
                    clr_idle_next   = 1'b0;
                    c_next          = '0;
                    state_next      = pap_pkg::S_CLR_ROW;
                end
                else
                begin
                    overflow_next = 1'b1;
                    dropped_next  = 1'b1;
                    state_next    = pap_pkg::S_INS_END;
                end
            end

            pap_pkg::S_INS_END:
            begin
                if (last_reg)
                begin
                    if (!dropped_reg && cursor_reg != '0)
                    begin
                        mark_we = 1'b1;
                        mark_wa = cursor_reg;
                        mark_wd = 1'b1;
                    end
                    cursor_next  = '0;
                    dropped_next = 1'b0;
                end
                state_next = pap_pkg::S_IDLE;
            end

            pap_pkg::S_B_SYM_RD:
            begin
                goto_a_re  = 1'b1;
                goto_a_ra  = {r_reg, c_reg};
                goto_b_re  = 1'b1;
                goto_b_ra  = {fr_reg, c_reg};
                state_next = pap_pkg::S_B_SYM_EV;
            end

            pap_pkg::S_B_SYM_EV:
            begin
                if (goto_a_q == '0)
                begin
                    goto_we = 1'b1;
                    goto_wa = {r_reg, c_reg};
                    goto_wd = g_eff;
                    c_next  = c_reg + 1'b1;
                    if (c_reg == pap_pkg::LAST_SYM)
                    begin
                        root_next  = 1'b0;
                        state_next = pap_pkg::S_B_NODE;
                    end
                    else
                    begin
                        state_next = pap_pkg::S_B_SYM_RD;
                    end
                end
                else
                begin
                    if (tail_reg < pap_pkg::MAX_CNT)
                    begin
                        queue_we  = 1'b1;
                        queue_wa  = tail_reg[NW-1:0];
                        queue_wd  = goto_a_q;
                        tail_next = tail_reg + 1'b1;
                    end
                    fail_we    = 1'b1;
                    fail_wa    = goto_a_q;
                    fail_wd    = g_eff;
                    mark_a_re  = 1'b1;
                    mark_a_ra  = goto_a_q;
                    mark_b_re  = 1'b1;
                    mark_b_ra  = g_eff;
                    bu_next    = goto_a_q;
                    state_next = pap_pkg::S_B_MARK;
                end
            end

            pap_pkg::S_B_MARK:
            begin
                mark_we = 1'b1;
                mark_wa = bu_reg;
                mark_wd = mark_a_q | mark_b_q;
                c_next  = c_reg + 1'b1;
                if (c_reg == pap_pkg::LAST_SYM)
                begin
                    root_next  = 1'b0;
                    state_next = pap_pkg::S_B_NODE;
                end
                else
                begin
                    state_next = pap_pkg::S_B_SYM_RD;
                end
            end

            pap_pkg::S_B_NODE:
            begin
                if (head_reg < tail_reg)
                begin
                    queue_re   = 1'b1;
                    queue_ra   = head_reg[NW-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = pap_pkg::S_B_FAIL;
                end
                else
                begin
                    built_next = 1'b1;
                    u_next     = '0;
                    state_next = pap_pkg::S_D_INIT;
                end
            end

            pap_pkg::S_B_FAIL:
            begin
                r_next     = queue_q;
                fail_re    = 1'b1;
                fail_ra    = queue_q;
                state_next = pap_pkg::S_B_FAIL2;
            end

            pap_pkg::S_B_FAIL2:
            begin
                fr_next    = fail_q;
                c_next     = '0;
                state_next = pap_pkg::S_B_SYM_RD;
            end

            pap_pkg::S_D_INIT:
            begin
                val_we = 1'b1;
                val_wa = {1'b0, u_reg};
                val_wd = pap_pkg::Q_ONE;
                u_next = u_reg + 1'b1;
                if (u_reg == last_node)
                begin
                    cur_next = 1'b0;
                    u_next   = '0;
                    l_next   = pap_pkg::LEN_W'(1);
                    state_next = (len_reg == '0) ? pap_pkg::S_D_OUT : pap_pkg::S_D_NODE;
                end
            end

            pap_pkg::S_D_NODE:
            begin
                i_next = '0;
                if (drawn == '0)
                begin
                    val_we   = 1'b1;
                    val_wa   = {~cur_reg, u_reg};
                    val_wd   = '0;
                    node_end = 1'b1;
                end
                else
                begin
                    state_next = pap_pkg::S_D_RUN;
                end
            end

            pap_pkg::S_D_RUN:
            begin
                if (i_reg < drawn)
                begin
                    goto_a_re    = 1'b1;
                    goto_a_ra    = {u_reg, i_reg[SW-1:0]};
                    prob_re      = 1'b1;
                    prob_ra      = i_reg[SW-1:0];
                    s1_vld_next  = 1'b1;
                    s1_last_next = (i_reg == drawn - 1'b1);
                    i_next       = i_reg + 1'b1;
                end
                if (mac_done)
                begin
                    val_we   = 1'b1;
                    val_wa   = {~cur_reg, u_reg};
                    val_wd   = mac_sum;
                    node_end = 1'b1;
                end
            end

            pap_pkg::S_D_OUT:
            begin
                val_re     = 1'b1;
                val_ra     = {cur_reg, NW'(0)};
                state_next = pap_pkg::S_D_RES;
            end

            pap_pkg::S_D_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_prob_next  = val_q;
                    out_full_next  = overflow_reg;
                    state_next     = pap_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pap_pkg::S_IDLE;
            end
        endcase

        if (node_end)
        begin
            if (u_reg == last_node)
            begin
                cur_next = ~cur_reg;
                u_next   = '0;
                if (l_reg == len_reg)
                begin
                    state_next = pap_pkg::S_D_OUT;
                end
                else
                begin
                    l_next     = l_reg + 1'b1;
                    state_next = pap_pkg::S_D_NODE;
                end
            end
            else
            begin
                u_next     = u_reg + 1'b1;
                state_next = pap_pkg::S_D_NODE;
            end
        end
    end

    // the mark bit arrives together with the value, in the cycle after stage 1
    always_comb
    begin
        mac_ctl      = s2_ctl_reg;
        mac_ctl.skip = mark_a_q;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg >= pap_pkg::CNT_W'(1) && node_count_reg <= pap_pkg::MAX_CNT)
        else $error("node count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == pap_pkg::S_D_RES))
        else $error("result raised outside the result state");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pap_pkg::S_B_NODE |-> head_reg <= tail_reg)
        else $error("breadth-first queue underflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == pap_pkg::S_D_RUN)
        else $error("node sum finished outside the recurrence");

endmodule

@@ hdl/pattern_avoidance_probability_top.sv @@
// Loading a pattern symbol inserts it into the trie; a new trie node adds a clear of its goto row.
// A run first builds the failure links (on the first run after loading), then
// initialises node values, then per length and node passes the drawn symbols
// through goto and value RAMs and the multiply-accumulate, then reads the result.
// One item at a time. After reset (and after each clear op) a pass clears the root
// goto row; the input is not ready until it ends.
// Top level: stream ports and APB register; depends on pap_pkg, pap_engine.
`timescale 1ns / 1ps

module pattern_avoidance_probability_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // symbol[5:0], probability[37:6], run_length[44:38]
    input  logic [1:0]  s_tuser,   // op[1:0]
    input  logic        s_tlast,   // last_of_pattern
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // avoid_probability[31:0]
    output logic        m_tuser,   // table_full
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [pap_pkg::DRAWN_W-1:0] symbols_in_use_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbols_in_use_reg <= pap_pkg::DRAWN_W'(64);
        end
        else if (psel && penable && pwrite && paddr[2] == pap_pkg::REG_SYMBOLS_IN_USE)
        begin
            symbols_in_use_reg <= pwdata[pap_pkg::DRAWN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == pap_pkg::REG_SYMBOLS_IN_USE)
        begin
            prdata = 32'(symbols_in_use_reg);
        end
    end

    pap_engine u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .op                (s_tuser),
        .symbol            (s_tdata[5:0]),
        .last_of_pattern   (s_tlast),
        .probability       (s_tdata[37:6]),
        .run_length        (s_tdata[44:38]),
        .symbols_in_use    (symbols_in_use_reg),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .avoid_probability (m_tdata),
        .table_full        (m_tuser)
    );

endmodule
